// ===== src/hcre_pkg.sv =====
`default_nettype none

package hcre_pkg;

    // fixed-point scale for the reciprocal tables
    localparam int FRAC_BITS = 12;
    localparam int SAT_NUM   = 255 << FRAC_BITS;
    localparam int HUE_NUM   = (180 << FRAC_BITS) / 6;
    localparam int HUE_SPAN  = 180;
    localparam int QUOT_BITS = 22;

    localparam int SAT_RC_W  = 20;
    localparam int HUE_RC_W  = 17;
    localparam int TRAW_W    = 12;
    localparam int PROD_S_W  = 8 + SAT_RC_W;
    localparam int PROD_H_W  = 24;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_HUE_LOW,
        REG_HUE_HIGH,
        REG_SAT_LOW,
        REG_SAT_HIGH,
        REG_VALUE_LOW,
        REG_VALUE_HIGH,
        REG_BINARY_MODE,
        REG_NONE
    } t_reg_idx;

    typedef logic [SAT_RC_W-1:0] t_sat_tab [256];
    typedef logic [HUE_RC_W-1:0] t_hue_tab [256];

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } t_pix;

    // after max/min and sector select
    typedef struct packed {
        t_pix                      pix;
        logic [7:0]                v;
        logic [7:0]                diff;
        logic signed [TRAW_W-1:0]  t;
    } t_s1;

    // after reciprocal lookup
    typedef struct packed {
        t_pix                      pix;
        logic [7:0]                v;
        logic [7:0]                diff;
        logic signed [TRAW_W-1:0]  t;
        logic [SAT_RC_W-1:0]       sat_rc;
        logic [HUE_RC_W-1:0]       hue_rc;
    } t_s2;

    // after the multiplies
    typedef struct packed {
        t_pix                       pix;
        logic [7:0]                 v;
        logic [PROD_S_W-1:0]        prod_s;
        logic signed [PROD_H_W-1:0] prod_h;
    } t_s3;

    typedef struct packed {
        logic [7:0] hue_low;
        logic [7:0] hue_high;
        logic [7:0] sat_low;
        logic [7:0] sat_high;
        logic [7:0] value_low;
        logic [7:0] value_high;
        logic       binary_mode;
    } t_cfg;

    // shift-subtract quotient, used only to build the tables at elaboration
    function automatic logic [QUOT_BITS-1:0] rdiv(input logic [QUOT_BITS-1:0] n,
                                                 input logic [QUOT_BITS-1:0] d);
        logic [QUOT_BITS:0]   rem;
        logic [QUOT_BITS-1:0] q;
        rem = '0;
        q   = '0;
        for (int k = QUOT_BITS - 1; k >= 0; k--) begin
            rem = {rem[QUOT_BITS-1:0], n[k]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(num / i), zero for i = 0
    function automatic t_sat_tab build_sat();
        t_sat_tab             tab;
        logic [QUOT_BITS-1:0] q;
        for (int i = 0; i < 256; i++) begin
            if (i == 0) begin
                tab[i] = '0;
            end else begin
                q      = rdiv(QUOT_BITS'(2 * SAT_NUM + i), QUOT_BITS'(2 * i));
                tab[i] = q[SAT_RC_W-1:0];
            end
        end
        return tab;
    endfunction

    function automatic t_hue_tab build_hue();
        t_hue_tab             tab;
        logic [QUOT_BITS-1:0] q;
        for (int i = 0; i < 256; i++) begin
            if (i == 0) begin
                tab[i] = '0;
            end else begin
                q      = rdiv(QUOT_BITS'(2 * HUE_NUM + i), QUOT_BITS'(2 * i));
                tab[i] = q[HUE_RC_W-1:0];
            end
        end
        return tab;
    endfunction

    localparam t_sat_tab SAT_RECIP = build_sat();
    localparam t_hue_tab HUE_RECIP = build_hue();

endpackage

`default_nettype wire

// ===== src/hsv_color_range_extract_top.sv =====
`default_nettype none

// channel   valid     ready     payload
// input     i_valid   o_ready   i_blue_in, i_green_in, i_red_in
// output    o_valid   i_ready   o_blue_out, o_green_out, o_red_out, o_inside_range
// config    i_cfg_we  -         i_cfg_index, i_cfg_data
//
// One item per clock sustained while i_ready is high; four register stages, so o_valid
// rises once an accepted item has passed through all four of them.
// Stages: max/min and hue sector, reciprocal table lookup, the two multiplies,
// then rounding, hue wrap, limit compares and the output register.
// Each stage stalls only when it is full and the next one cannot take its item,
// so bubbles are squeezed out while the output waits.
// Synchronous active-low reset empties the pipeline and loads the default limits.

module hsv_color_range_extract_top
    import hcre_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_blue_in,
    input  wire logic [7:0] i_green_in,
    input  wire logic [7:0] i_red_in,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_blue_out,
    output logic [7:0]      o_green_out,
    output logic [7:0]      o_red_out,
    output logic            o_inside_range,
    input  wire logic       i_cfg_we,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_low     <= 8'd0;
            r_cfg.hue_high    <= 8'd100;
            r_cfg.sat_low     <= 8'd0;
            r_cfg.sat_high    <= 8'd255;
            r_cfg.value_low   <= 8'd0;
            r_cfg.value_high  <= 8'd255;
            r_cfg.binary_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HUE_LOW:     r_cfg.hue_low     <= i_cfg_data;
                REG_HUE_HIGH:    r_cfg.hue_high    <= i_cfg_data;
                REG_SAT_LOW:     r_cfg.sat_low     <= i_cfg_data;
                REG_SAT_HIGH:    r_cfg.sat_high    <= i_cfg_data;
                REG_VALUE_LOW:   r_cfg.value_low   <= i_cfg_data;
                REG_VALUE_HIGH:  r_cfg.value_high  <= i_cfg_data;
                REG_BINARY_MODE: r_cfg.binary_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    t_pix in_pix;
    t_pix out_pix;
    t_s1  s1_data;
    t_s3  s3_data;
    logic s1_valid;
    logic s1_ready;
    logic s3_valid;
    logic s3_ready;

    assign in_pix.b = i_blue_in;
    assign in_pix.g = i_green_in;
    assign in_pix.r = i_red_in;

    hcre_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_pix   (in_pix),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    hcre_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_data  (s3_data)
    );

    hcre_decide u_decide (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s3_valid),
        .o_ready  (s3_ready),
        .i_data   (s3_data),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_pix    (out_pix),
        .o_inside (o_inside_range)
    );

    assign o_blue_out  = out_pix.b;
    assign o_green_out = out_pix.g;
    assign o_red_out   = out_pix.r;

    // an accepted item always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> s1_valid)
        else $error("accepted item missing from first stage");

    // an outside pixel is black
    a_outside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_inside_range) |->
            (o_blue_out == 8'd0 && o_green_out == 8'd0 && o_red_out == 8'd0))
        else $error("outside pixel not black");

    // binary mode paints inside pixels white
    a_binary_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_inside_range && r_cfg.binary_mode) |->
            (o_blue_out == 8'd255 && o_green_out == 8'd255 && o_red_out == 8'd255))
        else $error("inside pixel not white in binary mode");

endmodule

`default_nettype wire

// ===== src/hcre_prep.sv =====
`default_nettype none

module hcre_prep
    import hcre_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_pix i_pix,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_s1       o_data
);

    logic r_valid;
    t_s1  r_data;
    t_s1  n_data;

    logic [7:0] vmax;
    logic [7:0] vmin;
    logic [7:0] diff;
    logic signed [TRAW_W-1:0] sb;
    logic signed [TRAW_W-1:0] sg;
    logic signed [TRAW_W-1:0] sr;
    logic signed [TRAW_W-1:0] d2;
    logic signed [TRAW_W-1:0] d4;

    always_comb begin
        vmax = i_pix.b;
        if (i_pix.g > vmax) vmax = i_pix.g;
        if (i_pix.r > vmax) vmax = i_pix.r;
        vmin = i_pix.b;
        if (i_pix.g < vmin) vmin = i_pix.g;
        if (i_pix.r < vmin) vmin = i_pix.r;
        diff = vmax - vmin;

        sb = $signed({4'b0, i_pix.b});
        sg = $signed({4'b0, i_pix.g});
        sr = $signed({4'b0, i_pix.r});
        d2 = $signed({3'b0, diff, 1'b0});
        d4 = $signed({2'b0, diff, 2'b0});

        n_data.pix  = i_pix;
        n_data.v    = vmax;
        n_data.diff = diff;
        // hue sector: red, then green, then blue takes priority
        if (vmax == i_pix.r) begin
            n_data.t = sg - sb;
        end else if (vmax == i_pix.g) begin
            n_data.t = sb - sr + d2;
        end else begin
            n_data.t = sr - sg + d4;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ===== src/hcre_mult.sv =====
`default_nettype none

module hcre_mult
    import hcre_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_s1  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_s3       o_data
);

    // stage a: reciprocal lookup, stage b: the two multiplies
    logic r_valid_a;
    t_s2  r_data_a;
    t_s2  n_data_a;
    logic ready_a;

    logic r_valid_b;
    t_s3  r_data_b;
    t_s3  n_data_b;
    logic ready_b;

    logic [PROD_S_W-1:0] prod_s;
    logic signed [TRAW_W+HUE_RC_W:0] prod_h;

    always_comb begin
        n_data_a.pix    = i_data.pix;
        n_data_a.v      = i_data.v;
        n_data_a.diff   = i_data.diff;
        n_data_a.t      = i_data.t;
        n_data_a.sat_rc = SAT_RECIP[i_data.v];
        n_data_a.hue_rc = HUE_RECIP[i_data.diff];
    end

    always_comb begin
        prod_s = PROD_S_W'(r_data_a.diff) * PROD_S_W'(r_data_a.sat_rc);
        prod_h = r_data_a.t * $signed({1'b0, r_data_a.hue_rc});
        n_data_b.pix    = r_data_a.pix;
        n_data_b.v      = r_data_a.v;
        n_data_b.prod_s = prod_s;
        n_data_b.prod_h = prod_h[PROD_H_W-1:0];
    end

    assign ready_b = !r_valid_b || i_ready;
    assign ready_a = !r_valid_a || ready_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (ready_a) r_valid_a <= i_valid;
            if (ready_b) r_valid_b <= r_valid_a;
        end
        if (ready_a && i_valid) begin
            r_data_a <= n_data_a;
        end
        if (ready_b && r_valid_a) begin
            r_data_b <= n_data_b;
        end
    end

    assign o_ready = ready_a;
    assign o_valid = r_valid_b;
    assign o_data  = r_data_b;

endmodule

`default_nettype wire

// ===== src/hcre_decide.sv =====
`default_nettype none

module hcre_decide
    import hcre_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_s3  i_data,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_pix      o_pix,
    output logic      o_inside
);

    logic r_valid;
    t_pix r_pix;
    logic r_inside;
    t_pix n_pix;
    logic n_inside;

    logic [PROD_S_W-1:0]        s_sum;
    logic signed [PROD_H_W-1:0] h_sum;
    logic signed [8:0]          h_raw;
    logic [8:0]                 h_wrap;
    logic [7:0]                 sat;
    logic [7:0]                 hue;

    always_comb begin
        s_sum = i_data.prod_s + PROD_S_W'(1 << (FRAC_BITS - 1));
        sat   = s_sum[FRAC_BITS+7:FRAC_BITS];
        // arithmetic shift gives the floor for negative sums
        h_sum = i_data.prod_h + PROD_H_W'(1 << (FRAC_BITS - 1));
        h_raw = h_sum[FRAC_BITS+8:FRAC_BITS];
        if (h_raw[8]) begin
            h_wrap = h_raw + 9'(HUE_SPAN);
        end else begin
            h_wrap = h_raw;
        end
        hue = h_wrap[7:0];

        n_inside = (hue >= i_cfg.hue_low) && (hue <= i_cfg.hue_high) &&
                   (sat >= i_cfg.sat_low) && (sat <= i_cfg.sat_high) &&
                   (i_data.v >= i_cfg.value_low) && (i_data.v <= i_cfg.value_high);

        if (!n_inside) begin
            n_pix = '0;
        end else if (i_cfg.binary_mode) begin
            n_pix = '1;
        end else begin
            n_pix = i_data.pix;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_pix    <= n_pix;
            r_inside <= n_inside;
        end
    end

    assign o_valid  = r_valid;
    assign o_pix    = r_pix;
    assign o_inside = r_inside;

endmodule

`default_nettype wire
